@@ hw/rtl/risc_instruction_field_decoder_unit_defines.svh @@
// Assertion macros used by the decoder checker.
`ifndef RISC_INSTRUCTION_FIELD_DECODER_UNIT_DEFINES_SVH
`define RISC_INSTRUCTION_FIELD_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RIFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rifd assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RIFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rifd assertion failed");

`endif

@@ hw/rtl/rifd_pkg.sv @@
`default_nettype none
package rifd_pkg;

	// Mnemonic codes, dense numbering, ILL is zero
	typedef enum logic [5:0] {
		MN_ILL, MN_LDSID, MN_MTSP, MN_AND, MN_NOP, MN_OR, MN_XOR, MN_SUB, MN_ADD,
		MN_SH1ADD, MN_SH2ADD, MN_LDX, MN_LDIL, MN_FLDDS, MN_FSTDS, MN_FLDDX,
		MN_FSTDX, MN_FTEST, MN_FCMP, MN_FADD, MN_FSUB, MN_FMUL, MN_FDIV, MN_LDO,
		MN_LDB, MN_LDH, MN_LDW, MN_STB, MN_STH, MN_STW, MN_COMBT, MN_COMIBT,
		MN_COMBF, MN_COMIBF, MN_ADDIBT, MN_ADDIBF, MN_EXTRS, MN_BE, MN_BLE,
		MN_BL, MN_BV
	} mnem_t;

	// How the immediate is reassembled
	typedef enum logic [2:0] {
		IMM_NONE, IMM_DISP14, IMM_IMM5, IMM_OFF12, IMM_BR17, IMM_LEFT21, IMM_EXTPOS
	} imm_form_t;

	typedef struct packed {
		mnem_t     mnem;
		imm_form_t form;
	} class_t;

	typedef struct packed {
		mnem_t              mnemonic;
		logic [4:0]         reg_a;
		logic [4:0]         reg_b;
		logic [4:0]         reg_c;
		logic [2:0]         space_reg;
		logic [2:0]         condition;
		logic [2:0]         load_size;
		logic signed [31:0] immediate;
		logic [5:0]         field_length;
	} result_t;

	// Major opcodes
	localparam logic [5:0] OP_SYS    = 6'h00;
	localparam logic [5:0] OP_ARITH  = 6'h02;
	localparam logic [5:0] OP_LDX    = 6'h03;
	localparam logic [5:0] OP_LDIL   = 6'h08;
	localparam logic [5:0] OP_FMEM   = 6'h0B;
	localparam logic [5:0] OP_FLOAT  = 6'h0C;
	localparam logic [5:0] OP_LDO    = 6'h0D;
	localparam logic [5:0] OP_LDB    = 6'h10;
	localparam logic [5:0] OP_LDH    = 6'h11;
	localparam logic [5:0] OP_LDW    = 6'h12;
	localparam logic [5:0] OP_STB    = 6'h18;
	localparam logic [5:0] OP_STH    = 6'h19;
	localparam logic [5:0] OP_STW    = 6'h1A;
	localparam logic [5:0] OP_COMBT  = 6'h20;
	localparam logic [5:0] OP_COMIBT = 6'h21;
	localparam logic [5:0] OP_COMBF  = 6'h22;
	localparam logic [5:0] OP_COMIBF = 6'h23;
	localparam logic [5:0] OP_ADDIBT = 6'h29;
	localparam logic [5:0] OP_ADDIBF = 6'h2B;
	localparam logic [5:0] OP_EXTRS  = 6'h34;
	localparam logic [5:0] OP_BE     = 6'h38;
	localparam logic [5:0] OP_BLE    = 6'h39;
	localparam logic [5:0] OP_BRANCH = 6'h3A;

	// System sub-opcodes (bits 12-5)
	localparam logic [7:0] SYS_LDSID = 8'h85;
	localparam logic [7:0] SYS_MTSP  = 8'hC1;

	// Arithmetic sub-opcodes (bits 11-5)
	localparam logic [6:0] SUB_AND    = 7'h10;
	localparam logic [6:0] SUB_OR     = 7'h12;
	localparam logic [6:0] SUB_XOR    = 7'h14;
	localparam logic [6:0] SUB_SUB    = 7'h20;
	localparam logic [6:0] SUB_ADD    = 7'h30;
	localparam logic [6:0] SUB_SH1ADD = 7'h32;
	localparam logic [6:0] SUB_SH2ADD = 7'h34;

	// Float types (bits 12-9)
	localparam logic [3:0] FT_TEST  = 4'd2;
	localparam logic [3:0] FT_CMP   = 4'd6;
	localparam logic [3:0] FT_ARITH = 4'd7;

	// Branch conditions of the BL/BV group
	localparam logic [2:0] BR_COND_BL = 3'd0;
	localparam logic [2:0] BR_COND_BV = 3'd6;

	localparam logic [5:0] EXT_WORD_BITS = 6'd32;

endpackage
`default_nettype wire

@@ hw/rtl/rifd_if.sv @@
`default_nettype none
// Instruction word channel
interface rifd_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction_word;

	modport source (output valid, output instruction_word, input ready);
	modport sink (input valid, input instruction_word, output ready);
endinterface

// Decoded result channel
interface rifd_out_if;
	logic               valid;
	logic               ready;
	logic [5:0]         mnemonic;
	logic [4:0]         reg_a;
	logic [4:0]         reg_b;
	logic [4:0]         reg_c;
	logic [2:0]         space_reg;
	logic [2:0]         condition;
	logic [2:0]         load_size;
	logic signed [31:0] immediate;
	logic [5:0]         field_length;

	modport source (output valid, output mnemonic, output reg_a, output reg_b,
		output reg_c, output space_reg, output condition, output load_size,
		output immediate, output field_length, input ready);
	modport sink (input valid, input mnemonic, input reg_a, input reg_b,
		input reg_c, input space_reg, input condition, input load_size,
		input immediate, input field_length, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rifd_classify.sv @@
`default_nettype none
module rifd_classify import rifd_pkg::*; (
	input  logic [31:0] word,
	output class_t      cls
);

	logic [5:0] op;
	logic [6:0] subop;
	logic [7:0] sysop;
	logic [3:0] ftype;
	logic [2:0] cond;

	assign op    = word[31:26];
	assign subop = word[11:5];
	assign sysop = word[12:5];
	assign ftype = word[12:9];
	assign cond  = word[15:13];

	// Resolve major opcode and sub-opcode into a mnemonic and immediate form
	always_comb begin
		cls.mnem = MN_ILL;
		cls.form = IMM_NONE;
		case (op)
			OP_SYS: begin
				if (sysop == SYS_LDSID) cls.mnem = MN_LDSID;
				else if (sysop == SYS_MTSP) cls.mnem = MN_MTSP;
			end
			OP_ARITH: begin
				case (subop)
					SUB_AND:    cls.mnem = MN_AND;
					SUB_OR:     cls.mnem = (word[25:16] == 10'd0 && word[4:0] == 5'd0)
						? MN_NOP : MN_OR;
					SUB_XOR:    cls.mnem = MN_XOR;
					SUB_SUB:    cls.mnem = MN_SUB;
					SUB_ADD:    cls.mnem = MN_ADD;
					SUB_SH1ADD: cls.mnem = MN_SH1ADD;
					SUB_SH2ADD: cls.mnem = MN_SH2ADD;
					default:    cls.mnem = MN_ILL;
				endcase
			end
			OP_LDX:  cls.mnem = MN_LDX;
			OP_LDIL: begin
				cls.mnem = MN_LDIL;
				cls.form = IMM_LEFT21;
			end
			OP_FMEM: begin
				if (word[12]) begin
					cls.mnem = word[9] ? MN_FSTDS : MN_FLDDS;
					cls.form = IMM_IMM5;
				end else begin
					cls.mnem = word[9] ? MN_FSTDX : MN_FLDDX;
				end
			end
			OP_FLOAT: begin
				if (ftype == FT_TEST) cls.mnem = MN_FTEST;
				else if (ftype == FT_CMP) cls.mnem = MN_FCMP;
				else if (ftype == FT_ARITH && !cond[2]) begin
					case (cond[1:0])
						2'd0:    cls.mnem = MN_FADD;
						2'd1:    cls.mnem = MN_FSUB;
						2'd2:    cls.mnem = MN_FMUL;
						default: cls.mnem = MN_FDIV;
					endcase
				end
			end
			OP_LDO: begin cls.mnem = MN_LDO; cls.form = IMM_DISP14; end
			OP_LDB: begin cls.mnem = MN_LDB; cls.form = IMM_DISP14; end
			OP_LDH: begin cls.mnem = MN_LDH; cls.form = IMM_DISP14; end
			OP_LDW: begin cls.mnem = MN_LDW; cls.form = IMM_DISP14; end
			OP_STB: begin cls.mnem = MN_STB; cls.form = IMM_DISP14; end
			OP_STH: begin cls.mnem = MN_STH; cls.form = IMM_DISP14; end
			OP_STW: begin cls.mnem = MN_STW; cls.form = IMM_DISP14; end
			OP_COMBT:  begin cls.mnem = MN_COMBT;  cls.form = IMM_OFF12; end
			OP_COMIBT: begin cls.mnem = MN_COMIBT; cls.form = IMM_OFF12; end
			OP_COMBF:  begin cls.mnem = MN_COMBF;  cls.form = IMM_OFF12; end
			OP_COMIBF: begin cls.mnem = MN_COMIBF; cls.form = IMM_OFF12; end
			OP_ADDIBT: begin cls.mnem = MN_ADDIBT; cls.form = IMM_OFF12; end
			OP_ADDIBF: begin cls.mnem = MN_ADDIBF; cls.form = IMM_OFF12; end
			OP_EXTRS:  begin cls.mnem = MN_EXTRS;  cls.form = IMM_EXTPOS; end
			OP_BE:     begin cls.mnem = MN_BE;     cls.form = IMM_BR17; end
			OP_BLE:    begin cls.mnem = MN_BLE;    cls.form = IMM_BR17; end
			OP_BRANCH: begin
				if (cond == BR_COND_BL) begin
					cls.mnem = MN_BL;
					cls.form = IMM_BR17;
				end else if (cond == BR_COND_BV) begin
					cls.mnem = MN_BV;
				end
			end
			default: begin
				cls.mnem = MN_ILL;
				cls.form = IMM_NONE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/rifd_operand.sv @@
`default_nettype none
module rifd_operand import rifd_pkg::*; (
	input  logic [31:0] word,
	input  class_t      cls,
	output result_t     res
);

	logic sgn;

	assign sgn = word[0];

	// Gather register, space, condition and size fields, then rebuild the immediate
	always_comb begin
		res.mnemonic  = cls.mnem;
		res.reg_a     = word[25:21];
		res.reg_b     = word[20:16];
		res.reg_c     = word[4:0];
		res.space_reg = {word[13], word[15], word[14]};
		res.condition = (cls.mnem == MN_FCMP) ? word[4:2] : word[15:13];
		res.load_size = (cls.mnem == MN_LDX) ? word[8:6] : 3'd0;
		res.field_length = (cls.mnem == MN_EXTRS)
			? EXT_WORD_BITS - {1'b0, word[4:0]} : 6'd0;

		// Reassemble the immediate from its scattered bits
		case (cls.form)
			IMM_DISP14: res.immediate = {{19{sgn}}, word[13:1]};
			IMM_IMM5:   res.immediate = {{28{word[16]}}, word[20:17]};
			IMM_OFF12:  res.immediate = {{21{sgn}}, word[2], word[12:3]};
			IMM_BR17:   res.immediate = {{14{sgn}}, word[20:16], word[2], word[12:3], 2'b00};
			IMM_LEFT21: res.immediate = {word[0], word[11:1], word[15:14], word[20:16],
				word[13:12], 11'd0};
			IMM_EXTPOS: res.immediate = {27'd0, word[9:5]};
			default:    res.immediate = 32'sd0;
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/risc_instruction_field_decoder_unit.sv @@
// Instruction field decoder, three register stages: input, classify, operands.
// A result passes the input, classify and operand registers before it is valid.
// Throughput: one item per cycle; a stall holds full stages, empty ones still fill.
// Reset (arst_n low, asynchronous) clears the stage valid bits only.
`default_nettype none
module risc_instruction_field_decoder_unit import rifd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rifd_in_if.sink   in_ch,
	rifd_out_if.source out_ch
);

	logic        valid_s1, valid_s2, valid_s3;
	logic [31:0] word_s1, word_s2;
	class_t      cls_s2;
	result_t     res_s3;
	class_t      cls_d;
	result_t     res_d;
	logic        adv1, adv2, adv3;

	// Each stage moves when it is empty or the stage after it moves
	assign adv3 = !valid_s3 || out_ch.ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign in_ch.ready = adv1;

	rifd_classify u_classify (
		.word (word_s1),
		.cls  (cls_d)
	);

	rifd_operand u_operand (
		.word (word_s2),
		.cls  (cls_s2),
		.res  (res_d)
	);

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_ch.valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	// Advance payload, hold on stall
	always_ff @(posedge clk) begin
		if (adv1 && in_ch.valid) word_s1 <= in_ch.instruction_word;
		if (adv2 && valid_s1) begin
			word_s2 <= word_s1;
			cls_s2  <= cls_d;
		end
		if (adv3 && valid_s2) res_s3 <= res_d;
	end

	// Drive the result channel
	assign out_ch.valid        = valid_s3;
	assign out_ch.mnemonic     = res_s3.mnemonic;
	assign out_ch.reg_a        = res_s3.reg_a;
	assign out_ch.reg_b        = res_s3.reg_b;
	assign out_ch.reg_c        = res_s3.reg_c;
	assign out_ch.space_reg    = res_s3.space_reg;
	assign out_ch.condition    = res_s3.condition;
	assign out_ch.load_size    = res_s3.load_size;
	assign out_ch.immediate    = res_s3.immediate;
	assign out_ch.field_length = res_s3.field_length;

endmodule
`default_nettype wire

@@ hw/rtl/rifd_checker.sv @@
`default_nettype none
`include "risc_instruction_field_decoder_unit_defines.svh"
module rifd_checker import rifd_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [5:0]         mnemonic,
	input wire logic [2:0]         load_size,
	input wire logic signed [31:0] immediate,
	input wire logic [5:0]         field_length
);

	// A stalled item stays and holds its code and immediate
	`RIFD_ASSERT_NXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(mnemonic) && $stable(immediate))

	// Codes stop at the last mnemonic
	`RIFD_ASSERT_IMP(a_code_range, clk, arst_n, out_valid, mnemonic <= MN_BV)

	// Field length is given exactly for EXTRS
	`RIFD_ASSERT_IMP(a_flen_extrs, clk, arst_n, out_valid, (mnemonic == MN_EXTRS) == (field_length != 6'd0))

	// Load size only for indexed loads
	`RIFD_ASSERT_IMP(a_lsize_ldx, clk, arst_n, out_valid && mnemonic != MN_LDX, load_size == 3'd0)

endmodule

bind risc_instruction_field_decoder_unit rifd_checker u_rifd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.mnemonic     (out_ch.mnemonic),
	.load_size    (out_ch.load_size),
	.immediate    (out_ch.immediate),
	.field_length (out_ch.field_length)
);
`default_nettype wire
